// ===== design/usfd_pkg.sv =====
// usfd_pkg: shared types and constants for the string field deframer
// used by every module of uleb128_string_field_deframer; no dependencies
package usfd_pkg;

  localparam int unsigned LEN_W    = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned GROUP_W  = 3;

  // number of 7-bit length groups that still land inside 32 bits
  localparam logic [GROUP_W-1:0] GROUP_STOP = 3'd5;

  localparam logic [1:0] MODE_STRING = 2'd0;
  localparam logic [1:0] MODE_HASH   = 2'd1;
  localparam logic [1:0] MODE_SKIP   = 2'd2;

  localparam logic REG_FIELD_MODE = 1'b0;

  typedef enum logic [2:0] {
    PH_MARKER  = 3'b001,
    PH_LENGTH  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0]  field_length;
    logic              field_last;
    logic              field_empty;
    logic              data_valid;
    logic [BYTE_W-1:0] out_byte;
  } result_t;

endpackage

// ===== design/usfd_cfg_regs.sv =====
// usfd_cfg_regs: apb-style register port holding the field mode
// depends on usfd_pkg
module usfd_cfg_regs import usfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [1:0]  field_mode
);

  logic [1:0] mode_r;
  logic [1:0] mode_nxt;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    mode_nxt = mode_r;
    if (wr_en && (cfg_paddr[2] == REG_FIELD_MODE)) begin
      mode_nxt = cfg_pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STRING;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_FIELD_MODE) begin
      cfg_prdata = {30'd0, mode_r};
    end
  end

  assign field_mode = mode_r;

endmodule

// ===== design/usfd_parser.sv =====
// usfd_parser: marker / uleb128 length / payload parsing state, one byte per transfer
// depends on usfd_pkg
module usfd_parser import usfd_pkg::*; #(
  parameter int unsigned HASH_MAX_LEN = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_fire,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic [1:0]        field_mode,
  output logic              res_valid,
  output result_t           res
);

  phase_t             phase_r, phase_nxt;
  logic [LEN_W-1:0]   accum_r, accum_nxt;
  logic [GROUP_W-1:0] group_r, group_nxt;
  logic [LEN_W-1:0]   left_r, left_nxt;
  logic [LEN_W-1:0]   held_r, held_nxt;

  logic [LEN_W-1:0] accum_or;
  logic [LEN_W-1:0] len_capped;
  logic [LEN_W-1:0] left_dec;
  logic             skip;
  logic             last;

  assign skip = field_mode[1];
  assign left_dec = left_r - 32'd1;
  assign last = (left_dec == '0);

  always_comb begin
    case (group_r)
      3'd0:    accum_or = accum_r | {25'd0, byte_in[6:0]};
      3'd1:    accum_or = accum_r | {18'd0, byte_in[6:0], 7'd0};
      3'd2:    accum_or = accum_r | {11'd0, byte_in[6:0], 14'd0};
      3'd3:    accum_or = accum_r | {4'd0, byte_in[6:0], 21'd0};
      3'd4:    accum_or = accum_r | {byte_in[3:0], 28'd0};
      default: accum_or = accum_r;
    endcase
  end

  always_comb begin
    len_capped = accum_or;
    if ((field_mode == MODE_HASH) && (accum_or > 32'(HASH_MAX_LEN))) begin
      len_capped = 32'(HASH_MAX_LEN);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    group_nxt = group_r;
    left_nxt  = left_r;
    held_nxt  = held_r;
    res_valid = 1'b0;
    res       = '0;
    if (byte_fire) begin
      unique case (phase_r)
        PH_LENGTH: begin
          accum_nxt = accum_or;
          group_nxt = (group_r < GROUP_STOP) ? group_r + 3'd1 : group_r;
          if (!byte_in[7]) begin
            accum_nxt = '0;
            group_nxt = '0;
            held_nxt  = len_capped;
            left_nxt  = len_capped;
            if (len_capped == '0) begin
              phase_nxt       = PH_MARKER;
              res_valid       = 1'b1;
              res.field_empty = 1'b1;
              res.field_last  = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          left_nxt = left_dec;
          if (last) begin
            phase_nxt = PH_MARKER;
          end
          res.field_length = held_r;
          res.field_last   = last;
          if (skip) begin
            res_valid = last;
          end else begin
            res_valid       = 1'b1;
            res.data_valid  = 1'b1;
            res.out_byte    = byte_in;
          end
        end
        default: begin
          accum_nxt = '0;
          group_nxt = '0;
          left_nxt  = '0;
          if (byte_in == '0) begin
            phase_nxt       = PH_MARKER;
            held_nxt        = '0;
            res_valid       = 1'b1;
            res.field_empty = 1'b1;
            res.field_last  = 1'b1;
          end else begin
            phase_nxt = PH_LENGTH;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MARKER;
      accum_r <= '0;
      group_r <= '0;
      left_r  <= '0;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      group_r <= group_nxt;
      left_r  <= left_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== design/usfd_out_buf.sv =====
// usfd_out_buf: result register with skid entry decoupling the output stall
// depends on usfd_pkg
module usfd_out_buf import usfd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_accept,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop = main_valid_r && out_ready;
  assign can_accept = !skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

// ===== design/uleb128_string_field_deframer.sv =====
// uleb128_string_field_deframer: top level of the string field deframer
// depends on usfd_pkg, usfd_cfg_regs, usfd_parser, usfd_out_buf
//
// in_*: one packet byte per transfer. each field is a marker byte, a uleb128
// length, then the payload. out_*: at most one result per input byte: payload
// bytes (string or hash mode), one end result per field in skip mode, or one
// empty-field result for a zero marker or zero length. out_tlast marks the
// final result of a field. cfg_*: apb port, field_mode at byte address 0
// (0 string, 1 hash with length capped at HASH_MAX_LEN, 2 or 3 skip).
// one byte is taken every cycle while in_tready is high; parser state updates
// at the input transfer and its result is registered in the buffer. a two-entry
// result buffer (output register plus skid) lets input keep flowing when the
// receiver stalls; in_tready drops only while the skid entry is occupied.
// reset (synchronous rst_n) returns the parser to expecting a marker, clears
// the length state and selects string mode; no clearing pass is needed.
module uleb128_string_field_deframer import usfd_pkg::*; #(
  parameter int unsigned HASH_MAX_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // [7:0] out_byte, [39:8] field_length
  output logic [1:0]  out_tuser,    // [0] data_valid, [1] field_empty
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [1:0] field_mode;
  logic       byte_fire;
  logic       res_valid;
  logic       can_accept;
  result_t    res;
  result_t    out_res;

  assign in_tready = can_accept;
  assign byte_fire = in_tvalid && can_accept;

  usfd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .field_mode  (field_mode)
  );

  usfd_parser #(
    .HASH_MAX_LEN (HASH_MAX_LEN)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_fire  (byte_fire),
    .byte_in    (in_tdata),
    .field_mode (field_mode),
    .res_valid  (res_valid),
    .res        (res)
  );

  usfd_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (can_accept),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {out_res.field_length, out_res.out_byte};
  assign out_tuser = {out_res.field_empty, out_res.data_valid};
  assign out_tlast = out_res.field_last;

endmodule

// ===== verif/uleb128_string_field_deframer_tb.sv =====
// testbench for uleb128_string_field_deframer: drives packet bytes and mode writes,
// predicts every result from a cycle-free model of the field parser and checks them
// depends on usfd_pkg and the design files only
module uleb128_string_field_deframer_tb;
  import usfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] HASH_CAP = 32'd32;
  localparam logic [1:0] MODE_SKIP_ALT = 2'd3;
  localparam logic [2:0] ADDR_FIELD_MODE = {REG_FIELD_MODE, 2'b00};
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 90;
  localparam int unsigned RANDOM_BYTES = 257;

  typedef struct {
    phase_t      phase;
    logic [31:0] accum;
    int unsigned shift;
    logic [31:0] left;
    logic [31:0] held;
  } parse_view_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic [7:0]  pending_bytes[$];
  logic [7:0]  length_bytes[$];
  result_t     expected_results[$];
  parse_view_t dut_view;
  parse_view_t plan_view;
  logic [1:0]  mode_now = MODE_STRING;
  logic [1:0]  plan_mode = MODE_STRING;
  int unsigned spill_bytes = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          byte_taken = 1'b0;
  bit          hold_arm = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_count = 0;
  int unsigned error_count = 0;
  result_t     predicted;

  uleb128_string_field_deframer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),      // [7:0] in_byte
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),     // [7:0] out_byte, [39:8] field_length
    .out_tuser   (out_tuser),     // [0] data_valid, [1] field_empty
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  function automatic parse_view_t fresh_view();
    parse_view_t v;
    v.phase = PH_MARKER;
    v.accum = '0;
    v.shift = 0;
    v.left = '0;
    v.held = '0;
    return v;
  endfunction

  // one byte through the parser; returns 1 when the byte yields a result
  function automatic bit deframe_step(inout parse_view_t s, input logic [1:0] mode,
                                      input logic [7:0] b, output result_t r);
    logic [38:0] group;
    logic [31:0] len;
    bit last;
    r = '0;
    case (s.phase)
      PH_LENGTH: begin
        if (s.shift < 32) begin
          group = 39'(b[6:0]) << s.shift;
          s.accum |= group[31:0];
          s.shift += 7;
        end
        if (b[7]) return 1'b0;
        len = s.accum;
        if (mode == MODE_HASH && len > HASH_CAP) len = HASH_CAP;
        s.accum = '0;
        s.shift = 0;
        if (len == 0) begin
          s.phase = PH_MARKER;
          s.held = '0;
          s.left = '0;
          r.field_empty = 1'b1;
          r.field_last = 1'b1;
          return 1'b1;
        end
        s.held = len;
        s.left = len;
        s.phase = PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        s.left -= 1;
        last = (s.left == 0);
        if (last) s.phase = PH_MARKER;
        r.field_last = last;
        r.field_length = s.held;
        if (mode >= MODE_SKIP) return last;
        r.out_byte = b;
        r.data_valid = 1'b1;
        return 1'b1;
      end
      default: begin
        s.accum = '0;
        s.shift = 0;
        s.left = '0;
        if (b == 8'h00) begin
          s.phase = PH_MARKER;
          s.held = '0;
          r.field_empty = 1'b1;
          r.field_last = 1'b1;
          return 1'b1;
        end
        s.phase = PH_LENGTH;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 20)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic check_result();
    result_t seen;
    result_t want;
    seen.out_byte = out_tdata[7:0];
    seen.field_length = out_tdata[39:8];
    seen.data_valid = out_tuser[0];
    seen.field_empty = out_tuser[1];
    seen.field_last = out_tlast;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, length", seen.field_length, '0);
      return;
    end
    want = expected_results.pop_front();
    if (seen.out_byte !== want.out_byte)
      report_mismatch("out_byte", seen.out_byte, want.out_byte);
    if (seen.data_valid !== want.data_valid)
      report_mismatch("data_valid", seen.data_valid, want.data_valid);
    if (seen.field_empty !== want.field_empty)
      report_mismatch("field_empty", seen.field_empty, want.field_empty);
    if (seen.field_last !== want.field_last)
      report_mismatch("field_last", seen.field_last, want.field_last);
    if (seen.field_length !== want.field_length)
      report_mismatch("field_length", seen.field_length, want.field_length);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    result_t r;
    bit has_result;
    has_result = deframe_step(plan_view, plan_mode, b, r);
    pending_bytes.push_back(b);
  endtask

  // pick a field length and its encoding, with redundant and overlong forms
  task automatic plan_length();
    int unsigned pick;
    int unsigned npad;
    int unsigned nbytes;
    logic [31:0] v;
    logic [6:0] g;
    pick = $urandom_range(99);
    npad = 0;
    if (pick < 10 && pick >= 6) begin
      repeat (4) length_bytes.push_back(8'h80);
      length_bytes.push_back({1'b0, 3'($urandom_range(7)), 4'h0});
      return;
    end
    if (plan_mode == MODE_HASH && pick >= 10 && pick < 16) begin
      nbytes = $urandom_range(7, 5);
      repeat (nbytes - 1) length_bytes.push_back({1'b1, 7'($urandom_range(127))});
      length_bytes.push_back({1'b0, 7'($urandom_range(127))});
      spill_bytes = $urandom_range(4);
      return;
    end
    if (pick < 6) v = '0;
    else if (plan_mode == MODE_HASH && pick < 30) begin
      v = $urandom_range(48, 33);
      spill_bytes = v - HASH_CAP;
    end
    else if (pick < 60) v = $urandom_range(4, 1);
    else if (pick < 86) v = $urandom_range(16, 5);
    else v = $urandom_range(40, 17);
    if ($urandom_range(3) == 0) npad = $urandom_range(2, 1);
    do begin
      g = v[6:0];
      v = v >> 7;
      length_bytes.push_back({(v != 0 || npad > 0), g});
    end while (v != 0);
    for (int k = npad; k > 0; k--) length_bytes.push_back({(k > 1), 7'h00});
  endtask

  task automatic queue_random(input int unsigned count);
    logic [7:0] b;
    repeat (count) begin
      if (length_bytes.size() != 0) b = length_bytes.pop_front();
      else if (spill_bytes > 0 && plan_view.phase != PH_PAYLOAD) begin
        b = 8'($urandom_range(255));
        spill_bytes--;
      end
      else begin
        case (plan_view.phase)
          PH_LENGTH: begin
            plan_length();
            b = length_bytes.pop_front();
          end
          PH_PAYLOAD: b = 8'($urandom_range(255));
          default: b = ($urandom_range(99) < 8) ? 8'h00 : 8'($urandom_range(255, 1));
        endcase
      end
      queue_byte(b);
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = ADDR_FIELD_MODE;
    cfg_pwdata = 32'(m);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    mode_now = m;
    plan_mode = m;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sender: holds a byte until its transfer, then idles or offers the next one
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || byte_taken)) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata <= pending_bytes.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      byte_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        if (deframe_step(dut_view, mode_now, in_tdata, predicted))
          expected_results.push_back(predicted);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  initial begin
    logic [7:0] opening[$];
    // empty by marker, empty by zero length, short payloads, a padded length,
    // a length whose high group wraps to zero and overruns, and a field that
    // is still open when the mode changes
    opening = '{8'h00, 8'hff, 8'h00, 8'h01, 8'h03, 8'h00, 8'hff, 8'h5a,
                8'h80, 8'h82, 8'h00, 8'h7f, 8'h80,
                8'h22, 8'h80, 8'h80, 8'h80, 8'h80, 8'h90, 8'h01,
                8'h44, 8'h03, 8'haa};
    dut_view = fresh_view();
    plan_view = fresh_view();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 79;
    foreach (opening[i]) queue_byte(opening[i]);
    wait_idle();
    write_mode(MODE_SKIP);
    queue_random(RANDOM_BYTES);

    wait_idle();
    send_idle_pct = 79;
    recv_idle_pct = 34;
    write_mode(MODE_SKIP_ALT);
    queue_random(RANDOM_BYTES);

    wait_idle();
    write_mode(MODE_STRING);
    queue_random(RANDOM_BYTES);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mode(MODE_HASH);
    queue_random(RANDOM_BYTES);
    repeat (20) @(posedge clk);
    hold_arm = 1'b1;

    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never seen", expected_results.size(), '0);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/usfd_pkg.sv
design/usfd_cfg_regs.sv
design/usfd_parser.sv
design/usfd_out_buf.sv
design/uleb128_string_field_deframer.sv
verif/uleb128_string_field_deframer_tb.sv
